// ===== hw/rtl/fbab_pkg.sv =====
// fbab_pkg: shared constants, types and helpers of the framebuffer blend-write block.
// No dependencies; every other file of the block refers to it by scoped names.
package fbab_pkg;

   // Surface limits and pixel store geometry
   localparam int MAX_WIDTH   = 256;
   localparam int MAX_HEIGHT  = 256;
   localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   // Field widths
   localparam int CSR_W      = 9;
   localparam int CSR_IDX_W  = 2;
   localparam int POS_W      = 16;
   localparam int CHAN_W     = 8;
   localparam int PIX_W      = 4 * CHAN_W;
   localparam int NUM_CHAN   = 3;
   localparam int REQ_DATA_W = 2 * POS_W + 4 * CHAN_W;
   localparam int RSP_DATA_W = PIX_W;

   // Blend arithmetic: colour numerator c*a + p*dA*(255-a)/255 needs 17 bits
   localparam int NUM_W = 17;
   localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'd255;
   localparam logic [CHAN_W-1:0] ALPHA_CLEAR  = 8'd0;

   // floor(x/255) for x < 255*2^16: (x * ceil(2^32/255)) >> 32
   localparam logic [24:0] DIV255_MAGIC = 25'd16843010;

   localparam int QUEUE_DEPTH = 2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;

   typedef enum logic {
      OP_BLEND = 1'b0,
      OP_READ  = 1'b1
   } op_type;

   // Classified request as it travels from front to back
   typedef struct packed {
      op_type              opcode;
      logic                in_bounds;
      logic [ADDR_W-1:0]   addr;
      logic [CHAN_W-1:0]   red;
      logic [CHAN_W-1:0]   green;
      logic [CHAN_W-1:0]   blue;
      logic [CHAN_W-1:0]   alpha;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } push_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_READ,
      BK_MUL,
      BK_SCALE,
      BK_SUM,
      BK_DIV
   } back_state_type;

   function automatic logic [15:0] div255(input logic [23:0] x);
      logic [48:0] prod;
      prod = 49'(x) * 49'(DIV255_MAGIC);
      return prod[47:32];
   endfunction

endpackage

// ===== hw/rtl/fbab_div.sv =====
// fbab_div: restoring divider lane, one quotient bit per cycle.
// Depends on fbab_pkg for NUM_W and CHAN_W.
module fbab_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [fbab_pkg::NUM_W-1:0]   numer,
   input  logic [fbab_pkg::CHAN_W-1:0]  denom,
   output logic [fbab_pkg::NUM_W-1:0]   quo,
   output logic                         done
);

   localparam int CNT_W = $clog2(fbab_pkg::NUM_W);

   logic                         busy_ff;
   logic                         done_ff;
   logic [CNT_W-1:0]             cnt_ff;
   logic [fbab_pkg::CHAN_W-1:0]  rem_ff, rem_in;
   logic [fbab_pkg::CHAN_W-1:0]  den_ff;
   logic [fbab_pkg::NUM_W-1:0]   quo_ff, quo_in;
   logic [fbab_pkg::CHAN_W:0]    trial;
   logic                         ge;

   always_comb begin
      trial  = {rem_ff, quo_ff[fbab_pkg::NUM_W-1]};
      ge     = (trial >= {1'b0, den_ff});
      rem_in = ge ? fbab_pkg::CHAN_W'(trial - {1'b0, den_ff}) : trial[fbab_pkg::CHAN_W-1:0];
      quo_in = {quo_ff[fbab_pkg::NUM_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= CNT_W'(fbab_pkg::NUM_W - 1);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         den_ff <= denom;
         quo_ff <= numer;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign quo  = quo_ff;
   assign done = done_ff;

endmodule

// ===== hw/rtl/fbab_front.sv =====
// fbab_front: surface size registers, request unpacking, clipping and address generation.
// Depends on fbab_pkg for widths, register indexes and the item type.
module fbab_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [fbab_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fbab_pkg::CSR_W-1:0]        csr_data,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [fbab_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              req_tuser,
   input  logic                              clearing,
   input  logic                              q_full,
   output fbab_pkg::push_type                push
);

   logic [fbab_pkg::CSR_W-1:0]   frame_width_ff;
   logic [fbab_pkg::CSR_W-1:0]   frame_height_ff;
   logic [fbab_pkg::CSR_W-1:0]   w_eff, h_eff;
   logic [fbab_pkg::POS_W-1:0]   pos_x, pos_y;
   logic                         x_ok, y_ok;
   logic [2*fbab_pkg::CSR_W-1:0] addr_full;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= '0;
         frame_height_ff <= '0;
      end else if (csr_valid) begin
         if (csr_index == fbab_pkg::CSR_FRAME_WIDTH)  frame_width_ff  <= csr_data;
         if (csr_index == fbab_pkg::CSR_FRAME_HEIGHT) frame_height_ff <= csr_data;
      end
   end

   always_comb begin
      // oversized registers saturate at the store geometry
      w_eff = (32'(frame_width_ff) > fbab_pkg::MAX_WIDTH) ?
              fbab_pkg::CSR_W'(fbab_pkg::MAX_WIDTH) : frame_width_ff;
      h_eff = (32'(frame_height_ff) > fbab_pkg::MAX_HEIGHT) ?
              fbab_pkg::CSR_W'(fbab_pkg::MAX_HEIGHT) : frame_height_ff;

      pos_x = req_tdata[15:0];
      pos_y = req_tdata[31:16];
      x_ok  = !pos_x[fbab_pkg::POS_W-1] && (pos_x < fbab_pkg::POS_W'(w_eff));
      y_ok  = !pos_y[fbab_pkg::POS_W-1] && (pos_y < fbab_pkg::POS_W'(h_eff));

      // in bounds, both coordinates fit CSR_W bits
      addr_full = (2*fbab_pkg::CSR_W)'(pos_y[fbab_pkg::CSR_W-1:0])
                * (2*fbab_pkg::CSR_W)'(w_eff)
                + (2*fbab_pkg::CSR_W)'(pos_x[fbab_pkg::CSR_W-1:0]);
   end

   assign req_tready = !q_full && !clearing;

   always_comb begin
      push.valid          = req_tvalid && req_tready;
      push.item.opcode    = fbab_pkg::op_type'(req_tuser);
      push.item.in_bounds = x_ok && y_ok;
      push.item.addr      = fbab_pkg::ADDR_W'(addr_full);
      push.item.red       = req_tdata[39:32];
      push.item.green     = req_tdata[47:40];
      push.item.blue      = req_tdata[55:48];
      push.item.alpha     = req_tdata[63:56];
   end

endmodule

// ===== hw/rtl/fbab_queue.sv =====
// fbab_queue: short FIFO of classified requests between front and back.
// Depends on fbab_pkg for QUEUE_DEPTH and the item type.
module fbab_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  fbab_pkg::push_type    push,
   output logic                  full,
   input  logic                  pop,
   output logic                  valid,
   output fbab_pkg::item_type    item
);

   localparam int PTR_W = $clog2(fbab_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(fbab_pkg::QUEUE_DEPTH + 1);

   fbab_pkg::item_type  entry_ff [fbab_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]    count_ff;
   logic                do_push, do_pop;

   assign full    = (count_ff == CNT_W'(fbab_pkg::QUEUE_DEPTH));
   assign valid   = (count_ff != '0);
   assign do_push = push.valid && !full;
   assign do_pop  = pop && valid;
   assign item    = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push)
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(fbab_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         if (do_pop)
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(fbab_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         if (do_push && !do_pop)      count_ff <= count_ff + 1'b1;
         else if (do_pop && !do_push) count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push.item;
   end

endmodule

// ===== hw/rtl/fbab_back.sv =====
// fbab_back: pixel store, clearing pass, read-modify-write blend engine and result register.
// Depends on fbab_pkg and instantiates three fbab_div lanes.
module fbab_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   input  fbab_pkg::item_type                q_item,
   output logic                              q_pop,
   output logic                              clearing,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [fbab_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tuser
);

   localparam int CW = fbab_pkg::CHAN_W;
   localparam int NC = fbab_pkg::NUM_CHAN;

   fbab_pkg::back_state_type state_ff, state_in;

   logic [fbab_pkg::PIX_W-1:0]   store_mem [fbab_pkg::STORE_DEPTH];

   fbab_pkg::item_type           item_ff;
   logic [fbab_pkg::PIX_W-1:0]   rd_pix_ff;
   logic [fbab_pkg::ADDR_W-1:0]  clr_ff;
   logic [15:0]                  prod1_ff;
   logic [15:0]                  da_scaled;
   logic [CW-1:0]                outa_ff;
   logic [15:0]                  cterm_ff [NC];
   logic [23:0]                  pd_ff    [NC];
   logic [CW-1:0]                src_c    [NC];
   logic [CW-1:0]                dst_c    [NC];
   logic [fbab_pkg::NUM_W-1:0]   numer    [NC];
   logic [fbab_pkg::NUM_W-1:0]   div_quo  [NC];
   logic [NC-1:0]                div_done;
   logic                         div_start;
   logic                         blend_needed;

   logic                         rsp_valid_ff;
   logic [fbab_pkg::PIX_W-1:0]   rsp_pix_ff;
   logic                         rsp_inb_ff;

   logic                         mem_we;
   logic [fbab_pkg::ADDR_W-1:0]  mem_waddr;
   logic [fbab_pkg::PIX_W-1:0]   mem_wdata;
   logic                         rsp_load;
   logic [fbab_pkg::PIX_W-1:0]   rsp_load_pix;
   logic                         rsp_load_inb;
   logic [fbab_pkg::PIX_W-1:0]   opaque_pix;
   logic [fbab_pkg::PIX_W-1:0]   blend_pix;

   always_comb begin
      src_c[0] = item_ff.red;
      src_c[1] = item_ff.green;
      src_c[2] = item_ff.blue;
      for (int ch = 0; ch < NC; ch++) begin
         dst_c[ch] = rd_pix_ff[ch*CW +: CW];
         numer[ch] = fbab_pkg::NUM_W'(cterm_ff[ch])
                   + fbab_pkg::NUM_W'(fbab_pkg::div255(pd_ff[ch]));
      end
      da_scaled    = fbab_pkg::div255(24'(prod1_ff));
      opaque_pix   = {fbab_pkg::ALPHA_OPAQUE, item_ff.blue, item_ff.green, item_ff.red};
      blend_pix    = (outa_ff == '0) ? '0 :
                     {outa_ff, div_quo[2][CW-1:0], div_quo[1][CW-1:0], div_quo[0][CW-1:0]};
      blend_needed = item_ff.in_bounds && (item_ff.opcode == fbab_pkg::OP_BLEND)
                  && (item_ff.alpha != fbab_pkg::ALPHA_CLEAR)
                  && (item_ff.alpha != fbab_pkg::ALPHA_OPAQUE);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fbab_pkg::BK_CLEAR:
            if (clr_ff == fbab_pkg::ADDR_W'(fbab_pkg::STORE_DEPTH - 1)) state_in = fbab_pkg::BK_IDLE;
         fbab_pkg::BK_IDLE:
            if (q_valid && !rsp_valid_ff) state_in = fbab_pkg::BK_READ;
         fbab_pkg::BK_READ:
            state_in = blend_needed ? fbab_pkg::BK_MUL : fbab_pkg::BK_IDLE;
         fbab_pkg::BK_MUL:   state_in = fbab_pkg::BK_SCALE;
         fbab_pkg::BK_SCALE: state_in = fbab_pkg::BK_SUM;
         fbab_pkg::BK_SUM:   state_in = fbab_pkg::BK_DIV;
         fbab_pkg::BK_DIV:
            if (&div_done) state_in = fbab_pkg::BK_IDLE;
         default: state_in = fbab_pkg::BK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = item_ff.addr;
      mem_wdata    = opaque_pix;
      rsp_load     = 1'b0;
      rsp_load_pix = rd_pix_ff;
      rsp_load_inb = 1'b1;
      div_start    = 1'b0;
      unique case (state_ff)
         fbab_pkg::BK_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
         end
         fbab_pkg::BK_IDLE:
            q_pop = q_valid && !rsp_valid_ff;
         fbab_pkg::BK_READ: begin
            priority if (!item_ff.in_bounds) begin
               rsp_load     = 1'b1;
               rsp_load_pix = '0;
               rsp_load_inb = 1'b0;
            end else if (blend_needed) begin
               rsp_load = 1'b0;
            end else if (item_ff.opcode == fbab_pkg::OP_BLEND
                         && item_ff.alpha == fbab_pkg::ALPHA_OPAQUE) begin
               mem_we       = 1'b1;
               rsp_load     = 1'b1;
               rsp_load_pix = opaque_pix;
            end else begin
               rsp_load = 1'b1;
            end
         end
         fbab_pkg::BK_SUM:
            div_start = 1'b1;
         fbab_pkg::BK_DIV:
            if (&div_done) begin
               mem_we       = 1'b1;
               mem_wdata    = blend_pix;
               rsp_load     = 1'b1;
               rsp_load_pix = blend_pix;
            end
         default: q_pop = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fbab_pkg::BK_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == fbab_pkg::BK_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (rsp_load)        rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   // payload: blend pipeline inputs hold steady from READ onward
   always_ff @(posedge clock) begin
      if (q_pop) item_ff <= q_item;
      prod1_ff <= 16'(rd_pix_ff[fbab_pkg::PIX_W-1 -: CW]) * 16'(fbab_pkg::ALPHA_OPAQUE - item_ff.alpha);
      outa_ff  <= item_ff.alpha + da_scaled[CW-1:0];
      for (int ch = 0; ch < NC; ch++) begin
         cterm_ff[ch] <= 16'(src_c[ch]) * 16'(item_ff.alpha);
         pd_ff[ch]    <= 24'(dst_c[ch]) * 24'(prod1_ff);
      end
      if (rsp_load) begin
         rsp_pix_ff <= rsp_load_pix;
         rsp_inb_ff <= rsp_load_inb;
      end
   end

   // pixel store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) store_mem[mem_waddr] <= mem_wdata;
   end

   always_ff @(posedge clock) begin
      if (q_pop) rd_pix_ff <= store_mem[q_item.addr];
   end

   for (genvar ch = 0; ch < NC; ch++) begin : g_lane
      fbab_div u_div (
         .clock (clock),
         .reset (reset),
         .start (div_start),
         .numer (numer[ch]),
         .denom (outa_ff),
         .quo   (div_quo[ch]),
         .done  (div_done[ch])
      );
   end

   assign clearing   = (state_ff == fbab_pkg::BK_CLEAR);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_pix_ff;
   assign rsp_tuser  = rsp_inb_ff;

endmodule

// ===== hw/rtl/framebuffer_alpha_blend_write.sv =====
// framebuffer_alpha_blend_write: top level of the RGBA8 framebuffer with source-over blend writes.
// Depends on fbab_pkg; instantiates fbab_front, fbab_queue and fbab_back.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+---------------------------------------
//   req_    | in        | req_tvalid/tready   | tdata pos, colour; tuser opcode
//   rsp_    | out       | rsp_tvalid/tready   | tdata stored pixel; tuser in_bounds
//   csr_    | in        | csr_valid/ready     | csr_index, csr_data (width, height)
//
// Back end: a read, clipped, transparent or opaque request passes through pop and read; a
//   translucent blend adds 3 arithmetic stages (MUL, SCALE, SUM), a divider step per quotient bit
//   and a done step; the next pop waits for an empty result register.
// Reset: after reset a clearing pass zeroes the 65536-word store, one word per cycle,
//   while req_tready stays low; csr writes are always taken.
// Stalls: a 2-entry queue takes requests, until full, while a stalled response sits in its register.
module framebuffer_alpha_blend_write (
   input  logic                              clock,
   input  logic                              reset,
   // request: [15:0] pos_x, [31:16] pos_y, [39:32] src_red, [47:40] src_green,
   //          [55:48] src_blue, [63:56] src_alpha
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [fbab_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              req_tuser,   // [0] opcode
   // response: [7:0] out_red, [15:8] out_green, [23:16] out_blue, [31:24] out_alpha
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [fbab_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tuser,   // [0] in_bounds
   // register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [fbab_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fbab_pkg::CSR_W-1:0]        csr_data
);

   fbab_pkg::push_type   push;
   fbab_pkg::item_type   q_item;
   logic                 q_full;
   logic                 q_valid;
   logic                 q_pop;
   logic                 clearing;

   // front: clip and compute y*width+x
   fbab_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .clearing   (clearing),
      .q_full     (q_full),
      .push       (push)
   );

   fbab_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (q_full),
      .pop   (q_pop),
      .valid (q_valid),
      .item  (q_item)
   );

   // back: read-modify-write of the pixel store
   fbab_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .clearing   (clearing),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== hw/rtl/fbab_checker.sv =====
// fbab_checker: port-level assertions for framebuffer_alpha_blend_write, bound to the top.
// Depends on fbab_pkg for data widths.
module fbab_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [fbab_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input logic                              rsp_tuser
);

   logic [2:0] inflight_ff, inflight_in;
   logic       req_acc, rsp_acc;

   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;

   always_comb begin
      inflight_in = inflight_ff;
      if (req_acc && !rsp_acc)      inflight_in = inflight_ff + 1'b1;
      else if (rsp_acc && !req_acc) inflight_in = inflight_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) inflight_ff <= '0;
      else       inflight_ff <= inflight_in;
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response dropped or changed while stalled");

   a_clip_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("clipped request returned a nonzero pixel");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("block active right after reset");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> inflight_ff != '0)
      else $error("response without an outstanding request");

   a_inflight_bound: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= 3'd4)
      else $error("more requests in flight than queue and stages hold");

endmodule

bind framebuffer_alpha_blend_write fbab_checker u_fbab_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== tb/tb_framebuffer_alpha_blend_write.sv =====
`timescale 1ns / 1ps
// tb_framebuffer_alpha_blend_write: self-checking bench for the RGBA8 blend-write framebuffer.
// Depends on fbab_pkg and framebuffer_alpha_blend_write. A directed table runs first, then
// random requests over several surface sizes, scored on the store mirror or a typed want.
module tb_framebuffer_alpha_blend_write;

   localparam int GAP_MAX     = 13;
   localparam int DRAIN_TAIL  = 40;    // outlasts the slowest blend plus the result register
   localparam int PHASE_REQS  = 170;
   localparam int PRINT_CAP   = 60;
   localparam int NUM_PHASES  = 8;

   // surface sizes for the random phases; a final phase picks its own
   localparam int PHASE_W [NUM_PHASES] = '{256, 16, 511, 1, 0, 5, 256, 3};
   localparam int PHASE_H [NUM_PHASES] = '{256, 16, 2, 300, 37, 7, 1, 256};

   // register slots past the two real ones; writes there must change nothing
   localparam logic [fbab_pkg::CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [fbab_pkg::CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   typedef struct packed {
      fbab_pkg::op_type                  opcode;
      logic signed [fbab_pkg::POS_W-1:0] pos_x;
      logic signed [fbab_pkg::POS_W-1:0] pos_y;
      logic [fbab_pkg::PIX_W-1:0]        color;   // {alpha, blue, green, red}, store word layout
   } pixel_req_type;

   typedef struct packed {
      logic [fbab_pkg::PIX_W-1:0] pixel;          // {alpha, blue, green, red}
      logic                       in_bounds;
   } pixel_rsp_type;

   typedef enum logic {
      ROW_REQ,
      ROW_FRAME                                   // resize: width in pos_x, height in pos_y
   } row_kind_type;

   typedef struct packed {
      row_kind_type  kind;
      pixel_req_type rq;
      logic          typed;                       // want holds a hand-written expectation
      pixel_rsp_type want;
   } table_row_type;

   // ---------------------------------------------------------------------------------------
   // Clock, DUT inputs at known values from time zero
   // ---------------------------------------------------------------------------------------
   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [fbab_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic                            req_tuser  = 1'b0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [fbab_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            rsp_tuser;
   logic                            csr_valid  = 1'b0;
   logic                            csr_ready;
   logic [fbab_pkg::CSR_IDX_W-1:0]  csr_index  = '0;
   logic [fbab_pkg::CSR_W-1:0]      csr_data   = '0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   framebuffer_alpha_blend_write u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // ---------------------------------------------------------------------------------------
   // Mirror of the block: pixel store, size registers, and the pixels still owed to us
   // ---------------------------------------------------------------------------------------
   logic [fbab_pkg::PIX_W-1:0] fb_mirror [fbab_pkg::STORE_DEPTH];
   logic [fbab_pkg::CSR_W-1:0] width_reg;
   logic [fbab_pkg::CSR_W-1:0] height_reg;
   pixel_rsp_type              pending_pixels [$];
   table_row_type              directed_rows [$];
   int                         err_count     = 0;
   int                         rsp_count     = 0;
   int                         quiet_run [2] = '{0, 0};    // [0] request side, [1] response side

   // register value as the block uses it: oversized values clamp to the store size
   function automatic int active_dim(input logic [fbab_pkg::CSR_W-1:0] reg_val, input int lim);
      return (int'(reg_val) > lim) ? lim : int'(reg_val);
   endfunction

   // integer source-over of a translucent colour onto one stored word
   function automatic logic [fbab_pkg::PIX_W-1:0] source_over(
         input logic [fbab_pkg::PIX_W-1:0] dst, input logic [fbab_pkg::PIX_W-1:0] src);
      int unsigned                a, inv, da, outa, num;
      int                         ch;
      logic [fbab_pkg::PIX_W-1:0] res;
      a    = src[31:24];
      inv  = 255 - a;
      da   = dst[31:24];
      outa = a + (da * inv) / 255;
      res  = '0;
      if (outa != 0) begin
         for (ch = 0; ch < fbab_pkg::NUM_CHAN; ch++) begin
            num = src[8*ch +: 8] * a + (dst[8*ch +: 8] * da * inv) / 255;
            res[8*ch +: 8] = 8'(num / outa);
         end
         res[31:24] = 8'(outa);
      end
      return res;
   endfunction

   // applies one request to the mirror and returns the pixel the block should send back
   function automatic pixel_rsp_type apply_request(input pixel_req_type rq);
      int            w, h, x, y, addr;
      pixel_rsp_type res;
      w   = active_dim(width_reg, fbab_pkg::MAX_WIDTH);
      h   = active_dim(height_reg, fbab_pkg::MAX_HEIGHT);
      x   = rq.pos_x;
      y   = rq.pos_y;
      res = '0;
      if (x >= 0 && y >= 0 && x < w && y < h) begin
         addr = y * w + x;
         if (rq.opcode == fbab_pkg::OP_BLEND && rq.color[31:24] != fbab_pkg::ALPHA_CLEAR) begin
            if (rq.color[31:24] == fbab_pkg::ALPHA_OPAQUE)
               fb_mirror[addr] = rq.color;
            else
               fb_mirror[addr] = source_over(fb_mirror[addr], rq.color);
         end
         res.pixel     = fb_mirror[addr];
         res.in_bounds = 1'b1;
      end
      return res;
   endfunction

   // idle cycles before the next request or response on one side; now and then a run with none at all
   function automatic int draw_gap(input int side);
      if (quiet_run[side] > 0) begin
         quiet_run[side]--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) begin
         quiet_run[side] = $urandom_range(8, 40);
         return 0;
      end
      return $urandom_range(0, GAP_MAX);
   endfunction

   // coordinate biased into a small corner so blends pile up on the same pixels
   function automatic logic signed [fbab_pkg::POS_W-1:0] pick_coord(input int lim);
      int v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: v = $urandom_range(0, (lim > 8) ? 7 : lim);
         6:                v = $urandom_range(0, 300);
         7:                v = lim - int'($urandom_range(0, 1));   // last column or just past
         8:                v = $urandom_range(0, 65535);          // anywhere in 16 bits
         default:          v = -int'($urandom_range(1, 4));
      endcase
      return fbab_pkg::POS_W'(v);
   endfunction

   function automatic void add_row(input row_kind_type kind, input fbab_pkg::op_type op,
                                   input int x, input int y,
                                   input logic [fbab_pkg::PIX_W-1:0] color,
                                   input logic typed,
                                   input logic [fbab_pkg::PIX_W-1:0] want_pixel,
                                   input logic want_in);
      table_row_type row;
      row.kind           = kind;
      row.rq.opcode      = op;
      row.rq.pos_x       = fbab_pkg::POS_W'(x);
      row.rq.pos_y       = fbab_pkg::POS_W'(y);
      row.rq.color       = color;
      row.typed          = typed;
      row.want.pixel     = want_pixel;
      row.want.in_bounds = want_in;
      directed_rows.push_back(row);
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (err_count < PRINT_CAP)
         $display("[%0t] response %0d: %s got %h expected %h", $time, rsp_count, what, got, want);
      err_count++;
   endtask

   task automatic check_response(input pixel_rsp_type got);
      pixel_rsp_type want;
      if (pending_pixels.size() == 0) begin
         report_mismatch("response with no request pending, pixel", got.pixel, '0);
      end else begin
         want = pending_pixels.pop_front();
         if (got.pixel[7:0] !== want.pixel[7:0])
            report_mismatch("out_red", got.pixel[7:0], want.pixel[7:0]);
         if (got.pixel[15:8] !== want.pixel[15:8])
            report_mismatch("out_green", got.pixel[15:8], want.pixel[15:8]);
         if (got.pixel[23:16] !== want.pixel[23:16])
            report_mismatch("out_blue", got.pixel[23:16], want.pixel[23:16]);
         if (got.pixel[31:24] !== want.pixel[31:24])
            report_mismatch("out_alpha", got.pixel[31:24], want.pixel[31:24]);
         if (got.in_bounds !== want.in_bounds)
            report_mismatch("in_bounds", got.in_bounds, want.in_bounds);
      end
      rsp_count++;
   endtask

   // ---------------------------------------------------------------------------------------
   // Request side. tvalid is only lowered when a gap follows, so back-to-back requests never
   // see a low and a high scheduled in the same step.
   // ---------------------------------------------------------------------------------------
   task automatic send_request(input pixel_req_type rq, input logic typed,
                               input pixel_rsp_type want);
      int            gap;
      pixel_rsp_type predicted;
      gap = draw_gap(0);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {rq.color, rq.pos_y, rq.pos_x};
      req_tuser  <= rq.opcode;
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      // accepted on this edge; the mirror moves on in request order
      predicted = apply_request(rq);
      pending_pixels.push_back(typed ? want : predicted);
   endtask

   // stop sending and hold off until every owed response is back
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_pixels.size() != 0) @(posedge clock);
   endtask

   // leaves csr_valid high; the caller lowers it after the last write of a batch
   task automatic csr_write(input logic [fbab_pkg::CSR_IDX_W-1:0] idx,
                            input logic [fbab_pkg::CSR_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      case (idx)
         fbab_pkg::CSR_FRAME_WIDTH:  width_reg  = val;
         fbab_pkg::CSR_FRAME_HEIGHT: height_reg = val;
         default: ;
      endcase
   endtask

   // resize only with the block drained; the spare slots get junk that must be ignored
   task automatic set_frame(input int w, input int h);
      wait_idle();
      csr_write(fbab_pkg::CSR_FRAME_WIDTH, fbab_pkg::CSR_W'(w));
      csr_write(fbab_pkg::CSR_FRAME_HEIGHT, fbab_pkg::CSR_W'(h));
      csr_write(CSR_SPARE_A, fbab_pkg::CSR_W'($urandom_range(0, 511)));
      csr_write(CSR_SPARE_B, fbab_pkg::CSR_W'($urandom_range(0, 511)));
      csr_valid <= 1'b0;
   endtask

   initial begin : request_side
      pixel_req_type rq;
      int            i, phase, n;

      for (i = 0; i < fbab_pkg::STORE_DEPTH; i++) fb_mirror[i] = '0;
      width_reg  = '0;
      height_reg = '0;

      // out of reset the surface is 0 x 0, so nothing is inside
      add_row(ROW_REQ, fbab_pkg::OP_BLEND, 0, 0, 32'hFF30_2010, 1, '0, 0);
      add_row(ROW_REQ, fbab_pkg::OP_READ, 0, 0, '0, 1, '0, 0);
      add_row(ROW_FRAME, fbab_pkg::OP_READ, 256, 256, '0, 0, '0, 0);
      // store comes up cleared, corners included
      add_row(ROW_REQ, fbab_pkg::OP_READ, 0, 0, '0, 1, '0, 1);
      add_row(ROW_REQ, fbab_pkg::OP_READ, 255, 255, 32'hFFFF_FFFF, 1, '0, 1);
      // opaque overwrites, transparent leaves the pixel alone
      add_row(ROW_REQ, fbab_pkg::OP_BLEND, 0, 0, 32'hFF33_2211, 1, 32'hFF33_2211, 1);
      add_row(ROW_REQ, fbab_pkg::OP_BLEND, 255, 255, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1);
      add_row(ROW_REQ, fbab_pkg::OP_BLEND, 0, 0, 32'h00AA_BBCC, 1, 32'hFF33_2211, 1);
      // translucent onto empty, onto translucent, onto opaque
      add_row(ROW_REQ, fbab_pkg::OP_BLEND, 1, 0, 32'h8032_64C8, 0, '0, 0);
      add_row(ROW_REQ, fbab_pkg::OP_BLEND, 1, 0, 32'h01FF_FFFF, 0, '0, 0);
      add_row(ROW_REQ, fbab_pkg::OP_BLEND, 0, 0, 32'hFE00_FF00, 0, '0, 0);
      add_row(ROW_REQ, fbab_pkg::OP_BLEND, 255, 255, 32'h8000_0000, 0, '0, 0);
      add_row(ROW_REQ, fbab_pkg::OP_READ, 1, 0, '0, 0, '0, 0);
      // clipped on every edge, store untouched and an all-zero response
      add_row(ROW_REQ, fbab_pkg::OP_BLEND, 256, 0, 32'hFFFF_FFFF, 1, '0, 0);
      add_row(ROW_REQ, fbab_pkg::OP_BLEND, 0, 256, 32'hFFFF_FFFF, 1, '0, 0);
      add_row(ROW_REQ, fbab_pkg::OP_READ, -1, 0, '0, 1, '0, 0);
      add_row(ROW_REQ, fbab_pkg::OP_BLEND, 0, -1, 32'hFFFF_FFFF, 1, '0, 0);
      add_row(ROW_REQ, fbab_pkg::OP_BLEND, -32768, -32768, 32'hFFFF_FFFF, 1, '0, 0);
      add_row(ROW_REQ, fbab_pkg::OP_READ, 32767, 32767, 32'hFFFF_FFFF, 1, '0, 0);
      // a read with every colour bit set must not write
      add_row(ROW_REQ, fbab_pkg::OP_READ, 0, 0, 32'hFFFF_FFFF, 0, '0, 0);
      // registers past the store size clamp to it
      add_row(ROW_FRAME, fbab_pkg::OP_READ, 511, 511, '0, 0, '0, 0);
      add_row(ROW_REQ, fbab_pkg::OP_READ, 255, 255, '0, 0, '0, 0);
      add_row(ROW_REQ, fbab_pkg::OP_READ, 256, 0, '0, 1, '0, 0);
      // single-pixel surface
      add_row(ROW_FRAME, fbab_pkg::OP_READ, 1, 1, '0, 0, '0, 0);
      add_row(ROW_REQ, fbab_pkg::OP_READ, 1, 0, '0, 1, '0, 0);
      add_row(ROW_REQ, fbab_pkg::OP_BLEND, 0, 0, 32'hFF01_0203, 1, 32'hFF01_0203, 1);
      // a new width readdresses the old words without clearing them
      add_row(ROW_FRAME, fbab_pkg::OP_READ, 3, 5, '0, 0, '0, 0);
      add_row(ROW_REQ, fbab_pkg::OP_READ, 1, 1, '0, 0, '0, 0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // the first request waits out the clearing pass on req_tready
      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_FRAME) begin
            set_frame(directed_rows[r].rq.pos_x, directed_rows[r].rq.pos_y);
         end else begin
            send_request(directed_rows[r].rq, directed_rows[r].typed, directed_rows[r].want);
         end
      end

      for (phase = 0; phase <= NUM_PHASES; phase++) begin
         if (phase < NUM_PHASES)
            set_frame(PHASE_W[phase], PHASE_H[phase]);
         else
            set_frame($urandom_range(0, 511), $urandom_range(0, 511));
         for (n = 0; n < PHASE_REQS; n++) begin
            // mid-phase hold-off: sender waits for the block to empty completely
            if (n == PHASE_REQS / 2 || $urandom_range(0, 149) == 0)
               wait_idle();
            rq.opcode       = ($urandom_range(0, 3) == 0) ? fbab_pkg::OP_READ
                                                           : fbab_pkg::OP_BLEND;
            rq.pos_x        = pick_coord(active_dim(width_reg, fbab_pkg::MAX_WIDTH));
            rq.pos_y        = pick_coord(active_dim(height_reg, fbab_pkg::MAX_HEIGHT));
            rq.color[23:0]  = 24'($urandom);
            case ($urandom_range(0, 7))
               0:       rq.color[31:24] = fbab_pkg::ALPHA_CLEAR;
               1:       rq.color[31:24] = fbab_pkg::ALPHA_OPAQUE;
               default: rq.color[31:24] = 8'($urandom_range(1, 254));
            endcase
            send_request(rq, 1'b0, '0);
         end
      end

      // all owed responses back, then a tail in which nothing more may show up
      wait_idle();
      repeat (DRAIN_TAIL) @(posedge clock);
      if (err_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // ---------------------------------------------------------------------------------------
   // Response side: random stall before each response, checked in arrival order
   // ---------------------------------------------------------------------------------------
   initial begin : response_side
      int stall;
      @(posedge clock);
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         stall = draw_gap(1);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (rsp_tvalid !== 1'b1) @(posedge clock);
         check_response({rsp_tdata, rsp_tuser});
      end
   end

   // clearing pass plus every request at its slowest comes to under a fifth of this
   initial begin : watchdog
      #10_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
